// ----- design/gimbal_axis_angle_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Gimbal axis angle controller assertion macros
// Concurrent assertion wrappers shared by the controller RTL. Defining
// NO_ASSERTIONS turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef GIMBAL_AXIS_ANGLE_CONTROLLER_ASSERT_SVH
`define GIMBAL_AXIS_ANGLE_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define GAAC_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gaac assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define GAAC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gaac assertion failed");
`else
`define GAAC_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define GAAC_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- design/gaac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal axis angle controller package
// Shared widths, codes, item structures and fixed-point angle helpers.
// ----------------------------------------------------------------------------
package gaac_pkg;

    // Axis selection and encoder resolution. The encoder must span a power
    // of two counts that matches the count width.
    localparam bit AXIS_IS_PITCH  = 1'b0;
    localparam int ENCODER_COUNTS = 8192;
    localparam int ENC_SHIFT      = $clog2(ENCODER_COUNTS);
    localparam int ENC_HALF       = ENCODER_COUNTS / 2;

    localparam int COUNT_W    = 13;
    localparam int ANGLE_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 12;
    localparam int WIDE_W     = 19;
    localparam int PROD_W     = GAIN_W + ANGLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;
    localparam int MODE_W     = 2;

    // Q3.12 angle constants.
    localparam logic signed [WIDE_W-1:0] PI_Q     = 19'sd12868;
    localparam logic signed [WIDE_W-1:0] NEG_PI_Q = -19'sd12868;
    localparam logic signed [WIDE_W-1:0] TWO_PI_Q = 19'sd25736;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAW  = 2'd0,
        MODE_GYRO = 2'd1,
        MODE_ENC  = 2'd2,
        MODE_HOLD = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_GAIN     = 3'd0,
        REG_ANGLE_GAIN  = 3'd1,
        REG_RATE_GAIN   = 3'd2,
        REG_OUT_MAX     = 3'd3,
        REG_OUT_MIN     = 3'd4,
        REG_ZERO_OFFSET = 3'd5,
        REG_PITCH_UPPER = 3'd6,
        REG_PITCH_LOWER = 3'd7
    } t_cfg_reg;

    // Item entering the setpoint stage.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] step;
        logic signed [ANGLE_W-1:0] imu;
        logic signed [ANGLE_W-1:0] grate;
        logic signed [ANGLE_W-1:0] speed;
        logic signed [ANGLE_W-1:0] current;
        logic signed [ANGLE_W-1:0] rel;
    } t_sp_in;

    // Item leaving the setpoint stage.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] setp;
        logic signed [ANGLE_W-1:0] meas;
        logic signed [ANGLE_W-1:0] rate;
        logic signed [ANGLE_W-1:0] current;
    } t_sp_out;

    // Angle of an encoder count relative to a reference count, rounded to
    // nearest with ties away from zero.
    function automatic logic signed [ANGLE_W-1:0] enc_angle(
        input logic [COUNT_W-1:0] cnt,
        input logic [COUNT_W-1:0] ref_cnt
    );
        localparam logic signed [COUNT_W+1:0] D_HALF = (COUNT_W+2)'(ENC_HALF);
        localparam logic signed [COUNT_W+1:0] D_FULL = (COUNT_W+2)'(ENCODER_COUNTS);
        localparam int MUL_W = COUNT_W + 16;
        logic signed [COUNT_W+1:0] d;
        logic [COUNT_W:0]          mag;
        logic [MUL_W-1:0]          prod;
        logic [MUL_W-1:0]          q;
        logic signed [ANGLE_W-1:0] res;
        d = $signed({2'b00, cnt}) - $signed({2'b00, ref_cnt});
        if (d > D_HALF) begin
            d = d - D_FULL;
        end else if (d < -D_HALF) begin
            d = d + D_FULL;
        end
        mag  = d[COUNT_W+1] ? (COUNT_W+1)'(-d) : (COUNT_W+1)'(d);
        prod = MUL_W'(mag) * MUL_W'(TWO_PI_Q);
        q    = (prod + MUL_W'(ENC_HALF)) >> ENC_SHIFT;
        res  = ANGLE_W'(q);
        return d[COUNT_W+1] ? -res : res;
    endfunction

    // Fold an angle into [-pi, pi]; three passes cover every caller's range.
    function automatic logic signed [WIDE_W-1:0] wrap_pi(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] y;
        y = x;
        for (int i = 0; i < 3; i++) begin
            if (y > PI_Q) begin
                y = y - TWO_PI_Q;
            end else if (y < NEG_PI_Q) begin
                y = y + TWO_PI_Q;
            end
        end
        return y;
    endfunction

    // Fold an angle into [0, 2pi].
    function automatic logic signed [WIDE_W-1:0] wrap_2pi(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] y;
        y = x;
        for (int i = 0; i < 3; i++) begin
            if (y < 0) begin
                y = y + TWO_PI_Q;
            end else if (y > TWO_PI_Q) begin
                y = y - TWO_PI_Q;
            end
        end
        return y;
    endfunction

endpackage

// ----- design/gaac_setpoint.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal axis setpoint stage
// Holds the mode history and the gyro and encoder setpoints, latches and
// accumulates them, and registers the item for the control stages.
// ----------------------------------------------------------------------------
module gaac_setpoint import gaac_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  t_sp_in                    i_item,
    input  logic signed [ANGLE_W-1:0] i_up_ang,
    input  logic signed [ANGLE_W-1:0] i_lo_ang,
    output t_sp_out                   o_item
);

    t_mode                     r_prev_mode;
    logic signed [ANGLE_W-1:0] r_abs_sp;
    logic signed [ANGLE_W-1:0] r_rel_sp;
    t_sp_out                   r_item;

    logic signed [ANGLE_W-1:0] n_abs_sp;
    logic signed [ANGLE_W-1:0] n_rel_sp;
    t_sp_out                   n_item;

    always_comb begin
        logic                      changed;
        logic signed [WIDE_W-1:0]  abs_base;
        logic signed [WIDE_W-1:0]  rel_base;
        logic signed [WIDE_W-1:0]  step;
        logic signed [WIDE_W-1:0]  rel;
        logic signed [WIDE_W-1:0]  err;
        logic signed [WIDE_W-1:0]  lim_max;
        logic signed [WIDE_W-1:0]  lim_min;
        logic signed [WIDE_W-1:0]  reach;
        logic signed [WIDE_W-1:0]  adj;
        logic signed [WIDE_W-1:0]  abs_new;
        logic signed [WIDE_W-1:0]  rel_new;
        logic signed [WIDE_W-1:0]  up;
        logic signed [WIDE_W-1:0]  lo;

        changed  = (i_item.mode != r_prev_mode);
        abs_base = changed ? WIDE_W'(i_item.imu) : WIDE_W'(r_abs_sp);
        rel_base = changed ? WIDE_W'(i_item.rel) : WIDE_W'(r_rel_sp);
        step     = WIDE_W'(i_item.step);
        rel      = WIDE_W'(i_item.rel);
        up       = WIDE_W'(i_up_ang);
        lo       = WIDE_W'(i_lo_ang);

        // Gyro mode: on the pitch axis the step is cut so that the implied
        // mechanical position stays between the encoder limits.
        err     = wrap_pi(abs_base - WIDE_W'(i_item.imu));
        lim_max = -up;
        lim_min = -lo;
        reach   = rel + err + step;
        adj     = step;
        if (AXIS_IS_PITCH) begin
            if (reach < lim_max) begin
                if (step[WIDE_W-1]) begin
                    adj = lim_max - rel - err;
                end
            end else if (reach > lim_min) begin
                if (!step[WIDE_W-1] && (step != '0)) begin
                    adj = lim_min - rel - err;
                end
            end
        end
        abs_new = wrap_pi(abs_base + adj);

        // Encoder mode: pitch is clamped, the upper limit taking priority;
        // yaw wraps to a full turn.
        rel_new = rel_base + step;
        if (AXIS_IS_PITCH) begin
            if (rel_new >= up) begin
                rel_new = up;
            end else if (rel_new <= lo) begin
                rel_new = lo;
            end
        end else begin
            rel_new = wrap_2pi(rel_new);
        end

        n_abs_sp       = r_abs_sp;
        n_rel_sp       = r_rel_sp;
        n_item.mode    = i_item.mode;
        n_item.current = i_item.current;
        n_item.setp    = '0;
        n_item.meas    = '0;
        n_item.rate    = '0;
        case (i_item.mode)
            MODE_RAW: begin
                n_item.setp = i_item.step;
            end
            MODE_GYRO: begin
                n_abs_sp    = ANGLE_W'(abs_new);
                n_item.setp = ANGLE_W'(abs_new);
                n_item.meas = i_item.imu;
                n_item.rate = i_item.grate;
            end
            MODE_ENC: begin
                n_rel_sp    = ANGLE_W'(rel_new);
                n_item.setp = ANGLE_W'(rel_new);
                n_item.meas = i_item.rel;
                n_item.rate = i_item.speed;
            end
            default: begin
                n_item.setp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mode <= MODE_RAW;
            r_abs_sp    <= '0;
            r_rel_sp    <= '0;
        end else if (i_load) begin
            r_prev_mode <= i_item.mode;
            r_abs_sp    <= n_abs_sp;
            r_rel_sp    <= n_rel_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- design/gimbal_axis_angle_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal axis angle controller
// PD position loop with current feedforward for one gimbal axis.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_axis channel is one control tick for the axis.
// tuser carries the mode (raw current, gyro angle or encoder angle); tdata
// carries the setpoint step, IMU angle, gyro rate, encoder count, motor
// speed and measured current. Each tick yields exactly one transaction on
// the m_axis channel holding the drive current and the active setpoint.
// Gains, output limits, the encoder zero and the pitch limits are written
// through the cfg channel, which is always ready; write them only while no
// tick is in flight.
// The datapath is a five-register pipeline (input, encoder angle, setpoint,
// angle error, gain products) ahead of the output register, and one tick is
// taken every cycle unless the receiver stalls while all stages hold a
// tick. The setpoint state and the last drive value are the only loops.
// Reset empties the pipeline, clears the setpoints, the remembered mode
// and the last drive value, and loads the registers' default values.
// When the receiver stalls, the result holds in the output register and
// the earlier stages keep filling; s_axis_tready falls only once all
// stages hold a tick.
// ----------------------------------------------------------------------------
`include "gimbal_axis_angle_controller_assert.svh"

module gimbal_axis_angle_controller import gaac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input ticks.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] setpoint_step, [31:16] imu_angle, [47:32] gyro_rate,
    // [60:48] encoder_count, [76:61] motor_speed, [92:77] measured_current,
    // [95:93] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // Results.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] drive_current, [31:16] active_setpoint
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = 54;
    localparam int FRAC  = 2 * GAIN_FRAC;
    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'(2**FRAC - 1);

    // Raw tick as taken from the bus.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] step;
        logic signed [ANGLE_W-1:0] imu;
        logic signed [ANGLE_W-1:0] grate;
        logic [COUNT_W-1:0]        ecd;
        logic signed [ANGLE_W-1:0] speed;
        logic signed [ANGLE_W-1:0] current;
    } t_in_item;

    // Tick after the wrapped angle error has been formed.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] setp;
        logic signed [ANGLE_W-1:0] err;
        logic signed [ANGLE_W-1:0] rate;
        logic signed [ANGLE_W-1:0] current;
    } t_err_item;

    // Tick carrying the three gain products.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] setp;
        logic signed [PROD_W-1:0]  p_ff;
        logic signed [PROD_W-1:0]  p_err;
        logic signed [PROD_W-1:0]  p_rate;
    } t_prod_item;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0]  r_ff_gain;
    logic signed [GAIN_W-1:0]  r_angle_gain;
    logic signed [GAIN_W-1:0]  r_rate_gain;
    logic signed [ANGLE_W-1:0] r_out_max;
    logic signed [ANGLE_W-1:0] r_out_min;
    logic [COUNT_W-1:0]        r_zero_offset;
    logic [COUNT_W-1:0]        r_pitch_upper;
    logic [COUNT_W-1:0]        r_pitch_lower;

    // Registered pitch limit angles; the user must ensure they are only
    // read well after any write has settled; no logic enforces it.
    logic signed [ANGLE_W-1:0] r_up_ang;
    logic signed [ANGLE_W-1:0] r_lo_ang;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_gain     <= '0;
            r_angle_gain  <= '0;
            r_rate_gain   <= '0;
            r_out_max     <= 16'sh7FFF;
            r_out_min     <= -16'sh8000;
            r_zero_offset <= '0;
            r_pitch_upper <= '1;
            r_pitch_lower <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FF_GAIN:     r_ff_gain     <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_ANGLE_GAIN:  r_angle_gain  <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_RATE_GAIN:   r_rate_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_OUT_MAX:     r_out_max     <= $signed(i_cfg_data[ANGLE_W-1:0]);
                REG_OUT_MIN:     r_out_min     <= $signed(i_cfg_data[ANGLE_W-1:0]);
                REG_ZERO_OFFSET: r_zero_offset <= i_cfg_data[COUNT_W-1:0];
                REG_PITCH_UPPER: r_pitch_upper <= i_cfg_data[COUNT_W-1:0];
                REG_PITCH_LOWER: r_pitch_lower <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_up_ang <= enc_angle(r_pitch_upper, r_zero_offset);
        r_lo_ang <= enc_angle(r_pitch_lower, r_zero_offset);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it is moving on, so bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_out_valid;
    logic ready1, ready2, ready3, ready4, ready5, ready_out;

    assign ready_out = !r_out_valid || m_axis_tready;
    assign ready5    = !r5_valid || ready_out;
    assign ready4    = !r4_valid || ready5;
    assign ready3    = !r3_valid || ready4;
    assign ready2    = !r2_valid || ready3;
    assign ready1    = !r1_valid || ready2;

    assign s_axis_tready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r1_valid <= s_axis_tvalid;
            end
            if (ready2) begin
                r2_valid <= r1_valid;
            end
            if (ready3) begin
                r3_valid <= r2_valid;
            end
            if (ready4) begin
                r4_valid <= r3_valid;
            end
            if (ready5) begin
                r5_valid <= r4_valid;
            end
            if (ready_out) begin
                r_out_valid <= r5_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    t_in_item r1;
    t_in_item n1;

    always_comb begin
        n1.mode    = t_mode'(s_axis_tuser);
        n1.step    = $signed(s_axis_tdata[15:0]);
        n1.imu     = $signed(s_axis_tdata[31:16]);
        n1.grate   = $signed(s_axis_tdata[47:32]);
        n1.ecd     = s_axis_tdata[60:48];
        n1.speed   = $signed(s_axis_tdata[76:61]);
        n1.current = $signed(s_axis_tdata[92:77]);
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1 <= n1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: relative angle from the encoder, mirrored on the pitch axis.
    // ------------------------------------------------------------------
    t_sp_in r2;
    t_sp_in n2;

    always_comb begin
        logic signed [ANGLE_W-1:0] ang;
        ang        = enc_angle(r1.ecd, r_zero_offset);
        n2.mode    = r1.mode;
        n2.step    = r1.step;
        n2.imu     = r1.imu;
        n2.grate   = r1.grate;
        n2.speed   = r1.speed;
        n2.current = r1.current;
        n2.rel     = AXIS_IS_PITCH ? -ang : ang;
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2 <= n2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: setpoint state. The state moves only when a valid tick
    // passes into this stage.
    // ------------------------------------------------------------------
    t_sp_out r3;

    gaac_setpoint u_setpoint (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r2_valid && ready3),
        .i_item   (r2),
        .i_up_ang (r_up_ang),
        .i_lo_ang (r_lo_ang),
        .o_item   (r3)
    );

    // ------------------------------------------------------------------
    // Stage 4: angle error, wrapped to half a turn.
    // ------------------------------------------------------------------
    t_err_item r4;
    t_err_item n4;

    always_comb begin
        logic signed [WIDE_W-1:0] diff;
        diff       = WIDE_W'(r3.setp) - WIDE_W'(r3.meas);
        n4.mode    = r3.mode;
        n4.setp    = r3.setp;
        n4.err     = ANGLE_W'(wrap_pi(diff));
        n4.rate    = r3.rate;
        n4.current = r3.current;
    end

    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r4 <= n4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: gain products, one 24 by 16 multiplier each.
    // ------------------------------------------------------------------
    t_prod_item r5;
    t_prod_item n5;

    always_comb begin
        n5.mode   = r4.mode;
        n5.setp   = r4.setp;
        n5.p_ff   = PROD_W'(r_ff_gain) * PROD_W'(r4.current);
        n5.p_err  = PROD_W'(r_angle_gain) * PROD_W'(r4.err);
        n5.p_rate = PROD_W'(r_rate_gain) * PROD_W'(r4.rate);
    end

    always_ff @(posedge i_clk) begin
        if (ready5) begin
            r5 <= n5;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum in units of 2^-24, saturate and truncate. The
    // encoder rate is in rpm and takes an extra factor of 2^12. A hold tick
    // repeats the previous drive value, which is tracked here in order.
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] r_out_drive;
    logic signed [ANGLE_W-1:0] r_out_active;
    logic signed [ANGLE_W-1:0] r_last_drive;
    logic signed [ANGLE_W-1:0] n_drive;

    always_comb begin
        logic signed [SUM_W-1:0]   rate_term;
        logic signed [SUM_W-1:0]   sum;
        logic signed [SUM_W-1:0]   lim_hi;
        logic signed [SUM_W-1:0]   lim_lo;
        logic signed [SUM_W-1:0]   q;
        logic signed [ANGLE_W-1:0] ctrl;

        rate_term = (r5.mode == MODE_ENC) ? (SUM_W'(r5.p_rate) <<< GAIN_FRAC)
                                          : SUM_W'(r5.p_rate);
        sum    = (SUM_W'(r5.p_ff) <<< GAIN_FRAC) + SUM_W'(r5.p_err) - rate_term;
        lim_hi = SUM_W'(r_out_max) <<< FRAC;
        lim_lo = SUM_W'(r_out_min) <<< FRAC;
        q      = sum[SUM_W-1] ? ((sum + TRUNC_BIAS) >>> FRAC) : (sum >>> FRAC);
        if (sum >= lim_hi) begin
            ctrl = r_out_max;
        end else if (sum <= lim_lo) begin
            ctrl = r_out_min;
        end else begin
            ctrl = ANGLE_W'(q);
        end

        case (r5.mode)
            MODE_RAW:  n_drive = r5.setp;
            MODE_GYRO: n_drive = ctrl;
            MODE_ENC:  n_drive = ctrl;
            default:   n_drive = r_last_drive;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_drive <= '0;
        end else if (ready_out && r5_valid) begin
            r_last_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            r_out_drive  <= n_drive;
            r_out_active <= r5.setp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_active, r_out_drive};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A hold tick must repeat the drive value of the tick before it.
    `GAAC_ASSERT_NEXT(a_hold_repeats, i_clk, i_rst_n, ready_out && r5_valid && (r5.mode == MODE_HOLD), $signed(m_axis_tdata[15:0]) == $past(r_last_drive))
    // In raw mode the drive current and the reported setpoint are the same.
    `GAAC_ASSERT_NEXT(a_raw_passthru, i_clk, i_rst_n, ready_out && r5_valid && (r5.mode == MODE_RAW), m_axis_tdata[15:0] == m_axis_tdata[31:16])
    // Input back-pressure appears only when every stage holds a tick.
    `GAAC_ASSERT_SAME(a_full_when_stalled, i_clk, i_rst_n, !s_axis_tready, r1_valid && r2_valid && r3_valid && r4_valid && r5_valid && r_out_valid)

endmodule

// ----- verif/gimbal_axis_angle_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal axis angle controller testbench
// Drives control ticks into the controller, predicts the drive current and
// the active setpoint of every tick with an independent fixed-point model,
// and compares each returned transaction in order. The run covers directed
// corner cases and random tick sequences, under several register settings
// and with random idling on both streams.
// ----------------------------------------------------------------------------
module gimbal_axis_angle_controller_tb import gaac_pkg::*;;

    localparam longint TURN_Q       = 25736;      // 2*pi in Q3.12
    localparam longint HALF_TURN_Q  = 12868;      // pi in Q3.12
    localparam longint DRIVE_SCALE  = 16777216;   // 2^24, units of the gain sum
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 12;         // pipeline depth plus margin
    localparam int     PHASE_TICKS  = 210;
    localparam int     PRINT_CAP    = 100;

    // One control tick as it travels on the input stream.
    typedef struct packed {
        t_mode                     mode;
        logic signed [ANGLE_W-1:0] step;
        logic signed [ANGLE_W-1:0] imu;
        logic signed [ANGLE_W-1:0] grate;
        logic [COUNT_W-1:0]        enc;
        logic signed [ANGLE_W-1:0] speed;
        logic signed [ANGLE_W-1:0] current;
    } t_tick;

    typedef struct packed {
        logic [ANGLE_W-1:0] drive;
        logic [ANGLE_W-1:0] setpoint;
    } t_result;

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the controller state and registers, the queue of
    // predicted results, and the mismatch count.
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        longint ff_gain     = 0;
        longint angle_gain  = 0;
        longint rate_gain   = 0;
        longint out_max     = 32767;
        longint out_min     = -32768;
        longint zero_count  = 0;
        longint upper_count = 8191;
        longint lower_count = 0;

        t_mode  prev_mode    = MODE_RAW;
        longint abs_setpoint = 0;
        longint rel_setpoint = 0;
        longint last_drive   = 0;

        t_result predicted_drives[$];
        int      mismatches  = 0;
        int      results_seen = 0;

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FF_GAIN:     ff_gain     = longint'($signed(val));
                REG_ANGLE_GAIN:  angle_gain  = longint'($signed(val));
                REG_RATE_GAIN:   rate_gain   = longint'($signed(val));
                REG_OUT_MAX:     out_max     = longint'($signed(val[15:0]));
                REG_OUT_MIN:     out_min     = longint'($signed(val[15:0]));
                REG_ZERO_OFFSET: zero_count  = longint'(val[COUNT_W-1:0]);
                REG_PITCH_UPPER: upper_count = longint'(val[COUNT_W-1:0]);
                REG_PITCH_LOWER: lower_count = longint'(val[COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted_drives.size();
        endfunction

        function longint clamp_s16(longint x);
            if (x > 32767) return 32767;
            if (x < -32768) return -32768;
            return x;
        endfunction

        function longint fold_half_turn(longint x);
            while (x > HALF_TURN_Q) x -= TURN_Q;
            while (x < -HALF_TURN_Q) x += TURN_Q;
            return x;
        endfunction

        // Angle of an encoder count from a reference, shortest way round,
        // rounded to nearest with ties away from zero.
        function longint count_to_angle(longint cnt, longint ref_cnt);
            longint d;
            longint p;
            d = cnt - ref_cnt;
            if (d > ENC_HALF) d -= ENCODER_COUNTS;
            else if (d < -ENC_HALF) d += ENCODER_COUNTS;
            p = d * TURN_Q;
            if (p >= 0) return (p + ENC_HALF) / ENCODER_COUNTS;
            return -((-p + ENC_HALF) / ENCODER_COUNTS);
        endfunction

        function longint drive_law(longint setp, longint meas, longint rate_scaled,
                                   longint cur);
            longint err;
            longint acc;
            err = fold_half_turn(setp - meas);
            acc = ff_gain * cur * 4096 + err * angle_gain - rate_scaled * rate_gain;
            if (acc >= out_max * DRIVE_SCALE) return out_max;
            if (acc <= out_min * DRIVE_SCALE) return out_min;
            return clamp_s16(acc / DRIVE_SCALE);
        endfunction

        function void note_tick(t_tick t);
            longint step;
            longint rel;
            longint s;
            longint e;
            longint hi;
            longint lo;
            longint drive;
            longint act;
            t_result r;
            step = t.step;
            rel  = count_to_angle(longint'(t.enc), zero_count);
            if (AXIS_IS_PITCH) rel = -rel;
            act  = 0;

            // Entering a mode latches its setpoint from the measurement.
            if (t.mode != prev_mode) begin
                if (t.mode == MODE_GYRO) abs_setpoint = t.imu;
                else if (t.mode == MODE_ENC) rel_setpoint = clamp_s16(rel);
            end
            prev_mode = t.mode;

            case (t.mode)
                MODE_RAW: begin
                    drive = step;
                    act   = step;
                end
                MODE_GYRO: begin
                    if (AXIS_IS_PITCH) begin
                        e  = fold_half_turn(abs_setpoint - longint'(t.imu));
                        hi = -count_to_angle(upper_count, zero_count);
                        lo = -count_to_angle(lower_count, zero_count);
                        if (rel + e + step < hi) begin
                            if (step < 0) step = hi - rel - e;
                        end else if (rel + e + step > lo) begin
                            if (step > 0) step = lo - rel - e;
                        end
                    end
                    abs_setpoint = clamp_s16(fold_half_turn(abs_setpoint + step));
                    drive = drive_law(abs_setpoint, t.imu, t.grate, t.current);
                    act   = abs_setpoint;
                end
                MODE_ENC: begin
                    s = rel_setpoint + step;
                    if (AXIS_IS_PITCH) begin
                        hi = count_to_angle(upper_count, zero_count);
                        lo = count_to_angle(lower_count, zero_count);
                        if (s >= hi) s = hi;
                        else if (s <= lo) s = lo;
                    end else begin
                        while (s < 0) s += TURN_Q;
                        while (s > TURN_Q) s -= TURN_Q;
                    end
                    rel_setpoint = clamp_s16(s);
                    drive = drive_law(rel_setpoint, rel, longint'(t.speed) * 4096, t.current);
                    act   = rel_setpoint;
                end
                default: begin
                    drive = last_drive;
                end
            endcase

            last_drive = drive;
            r.drive    = drive[ANGLE_W-1:0];
            r.setpoint = act[ANGLE_W-1:0];
            predicted_drives.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            // Keep the log readable when a fault repeats on every tick.
            if (mismatches <= PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
        endtask

        task check_result(logic [ANGLE_W-1:0] drive, logic [ANGLE_W-1:0] setp);
            t_result want;
            results_seen++;
            if (predicted_drives.size() == 0) begin
                report($sformatf("result %0d arrived with no tick outstanding", results_seen));
                return;
            end
            want = predicted_drives.pop_front();
            if (drive !== want.drive)
                report($sformatf("result %0d drive_current %0d, predicted %0d", results_seen,
                                 $signed(drive), $signed(want.drive)));
            if (setp !== want.setpoint)
                report($sformatf("result %0d active_setpoint %0d, predicted %0d", results_seen,
                                 $signed(setp), $signed(want.setpoint)));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    drive_scoreboard drive_sb;
    int    send_gap_pct = 0;   // chance in a hundred of an idle cycle before a tick
    int    stall_pct    = 0;   // chance in a hundred of the receiver stalling
    int    cycle_count  = 0;
    t_mode run_mode     = MODE_GYRO;

    gimbal_axis_angle_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // The receiver stalls at random; the rate follows the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Both streams are sampled at the edge, before the block's registers
    // update, so every transaction is seen exactly as the block saw it.
    // Input ticks are recorded before results are checked.
    always @(posedge i_clk) begin
        t_tick seen;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.mode    = t_mode'(s_axis_tuser);
                seen.step    = s_axis_tdata[15:0];
                seen.imu     = s_axis_tdata[31:16];
                seen.grate   = s_axis_tdata[47:32];
                seen.enc     = s_axis_tdata[60:48];
                seen.speed   = s_axis_tdata[76:61];
                seen.current = s_axis_tdata[92:77];
                drive_sb.note_tick(seen);
            end
            if (m_axis_tvalid && m_axis_tready)
                drive_sb.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16]);
        end
    end

    // A hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gimbal_axis_angle_controller test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic t_tick make_tick(t_mode mode, int step, int imu, int grate, int enc,
                                        int speed, int cur);
        t_tick t;
        t.mode    = mode;
        t.step    = 16'(step);
        t.imu     = 16'(imu);
        t.grate   = 16'(grate);
        t.enc     = 13'(enc);
        t.speed   = 16'(speed);
        t.current = 16'(cur);
        return t;
    endfunction

    // Mostly runs of one mode so that setpoints accumulate, with occasional
    // switches, a few hold ticks, and both small and full-range steps.
    function automatic t_tick random_tick();
        int pick;
        int step;
        if ($urandom_range(99) < 12) begin
            pick = $urandom_range(99);
            if (pick < 30) run_mode = MODE_RAW;
            else if (pick < 62) run_mode = MODE_GYRO;
            else if (pick < 94) run_mode = MODE_ENC;
            else run_mode = MODE_HOLD;
        end
        if ($urandom_range(99) < 70) step = int'($urandom_range(1000)) - 500;
        else step = $urandom;
        return make_tick(run_mode, step, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Log-uniform magnitude with a random sign, reaching from tiny to full scale.
    function automatic logic [GAIN_W-1:0] rand_gain();
        logic signed [GAIN_W-1:0] g;
        g = $signed(24'($urandom));
        return g >>> $urandom_range(20);
    endfunction

    // Valid stays high from one tick to the next unless an idle cycle is
    // drawn, so back-to-back transactions occur whenever no gap is chosen.
    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.mode;
        s_axis_tdata  <= {3'b000, t.current, t.speed, t.enc, t.grate, t.imu, t.step};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        drive_sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] ff, input logic [GAIN_W-1:0] ka,
                                  input logic [GAIN_W-1:0] kr, input logic [15:0] omax,
                                  input logic [15:0] omin, input logic [COUNT_W-1:0] zoff,
                                  input logic [COUNT_W-1:0] upper,
                                  input logic [COUNT_W-1:0] lower);
        cfg_write(REG_FF_GAIN, ff);
        cfg_write(REG_ANGLE_GAIN, ka);
        cfg_write(REG_RATE_GAIN, kr);
        cfg_write(REG_OUT_MAX, {{8{omax[15]}}, omax});
        cfg_write(REG_OUT_MIN, {{8{omin[15]}}, omin});
        cfg_write(REG_ZERO_OFFSET, 24'(zoff));
        cfg_write(REG_PITCH_UPPER, 24'(upper));
        cfg_write(REG_PITCH_LOWER, 24'(lower));
    endtask

    // Stop sending, wait until every predicted result has been returned,
    // then let the pipeline settle before anything else happens. The extra
    // edge lets the monitor record the last accepted tick first.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (drive_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        drive_sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: zero gains, so only the setpoints move.
        send_tick(make_tick(MODE_GYRO, 100, 5000, -300, 0, 0, 1000));
        send_tick(make_tick(MODE_ENC, 0, 0, 0, 8191, 0, 0));
        wait_drain();

        // Directed corners under moderate gains, with the zero offset at 100
        // so that half-turn and rounding-tie counts are easy to place.
        apply_settings(24'sd4096, 24'sh010000, 24'sh000800, 16'sd20000, -16'sd20000,
                       13'd100, 13'd6000, 13'd2000);
        send_tick(make_tick(MODE_RAW, 32767, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_RAW, -32768, 0, 0, 0, 0, 0));
        // Full-scale gyro ticks: the setpoint wraps, the output saturates.
        send_tick(make_tick(MODE_GYRO, 32767, 32767, 32767, 8191, 32767, 32767));
        send_tick(make_tick(MODE_GYRO, -32768, -32768, -32768, 0, -32768, -32768));
        send_tick(make_tick(MODE_GYRO, 0, 0, 0, 0, 0, 0));
        // Hold mode repeats the last drive and reports a zero setpoint.
        send_tick(make_tick(MODE_HOLD, 1234, 777, 55, 4000, 99, 5000));
        send_tick(make_tick(MODE_GYRO, 1, 12868, 100, 0, 0, 0));
        send_tick(make_tick(MODE_GYRO, 1, -12868, -100, 0, 0, 0));
        // Encoder counts exactly half a turn away, just past it, and on
        // rounding ties in both directions.
        send_tick(make_tick(MODE_ENC, 0, 0, 0, 100 + 4096, 32767, 0));
        send_tick(make_tick(MODE_ENC, 0, 0, 0, 100 + 4097, -32768, 0));
        send_tick(make_tick(MODE_ENC, 32767, 0, 0, 100 + 512, -32768, 32767));
        send_tick(make_tick(MODE_ENC, 100, 0, 0, 7780, 5, -32768));
        send_tick(make_tick(MODE_ENC, -32768, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_ENC, -32768, 0, 0, 99, 1, 1));
        send_tick(make_tick(MODE_HOLD, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_HOLD, -1, -1, -1, 8191, -1, -1));
        send_tick(make_tick(MODE_RAW, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_ENC, 25, 0, 0, 8191, 300, 2000));
        send_tick(make_tick(MODE_RAW, 5, 0, 0, 0, 0, 0));
        send_tick(make_tick(MODE_GYRO, -500, 30000, 20, 0, 0, -2000));

        // Random phases, each with its own register setting and idling.
        for (int ph = 0; ph < 4; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    // Largest gains and widest output range, no idling.
                    apply_settings(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'sd32767,
                                   -16'sd32768, 13'd0, 13'd8191, 13'd0);
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    apply_settings(rand_gain(), rand_gain(), rand_gain(), 16'sd1000,
                                   -16'sd1000, 13'd8191, 13'($urandom), 13'($urandom));
                    send_gap_pct = 59;
                    stall_pct    = 0;
                end
                2: begin
                    // Most negative gains and crossed output limits.
                    apply_settings(24'h800000, 24'h800000, 24'h800000, -16'sd100,
                                   16'sd100, 13'($urandom), 13'($urandom), 13'($urandom));
                    send_gap_pct = 0;
                    stall_pct    = 59;
                end
                default: begin
                    apply_settings(rand_gain(), rand_gain(), rand_gain(), 16'($urandom),
                                   16'($urandom), 13'($urandom), 13'($urandom),
                                   13'($urandom));
                    send_gap_pct = 16;
                    stall_pct    = 16;
                end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // Once, mid-phase, hold the sender until the pipeline empties.
                if (ph == 1 && n == PHASE_TICKS / 2) wait_drain();
                send_tick(random_tick());
            end
        end
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        wait_drain();

        if (drive_sb.mismatches == 0) begin
            $display("gimbal_axis_angle_controller test passed");
        end else begin
            $display("gimbal_axis_angle_controller test failed");
        end
        $finish;
    end

endmodule
